### rtl/nss_pkg.sv
// ----------------------------------------------------------------------------
// nss_pkg: shared definitions for the substring search block
// Store capacity, derived widths, operation codes and the control group that
// drives the row of pattern cells.
// ----------------------------------------------------------------------------
`default_nettype none

package nss_pkg;

    localparam int MAX_LEN = 255;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = 8;
    localparam int RES_W   = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APP_PAT = 2'd1,
        OP_APP_TXT = 2'd2,
        OP_SEARCH  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       shift;
        logic       start;
        logic       step;
        logic [7:0] new_byte;
        logic [7:0] text_byte;
    } t_row_ctl;

endpackage

`default_nettype wire

### rtl/nss_in_if.sv
// ----------------------------------------------------------------------------
// nss_in_if: command channel of the substring search block
// Carries one operation code and one byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_in;

    modport source (output valid, output operation, output char_in, input ready);
    modport sink   (input valid, input operation, input char_in, output ready);
endinterface

`default_nettype wire

### rtl/nss_out_if.sv
// ----------------------------------------------------------------------------
// nss_out_if: result channel of the substring search block
// Carries the match position, the found flag and the overflow flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] position;
    logic       found;
    logic       overflowed;

    modport source (output valid, output position, output found, output overflowed,
                    input ready);
    modport sink   (input valid, input position, input found, input overflowed,
                    output ready);
endinterface

`default_nettype wire

### rtl/naive_substring_search.sv
// ----------------------------------------------------------------------------
// naive_substring_search: first-occurrence substring search
// Clear and append beats are accepted one per cycle while no search runs.
// A search holds the command input off until its result beat is loaded; the
// text memory is read one byte per cycle into the cell chain. Empty pattern or
// text shorter than pattern: the result is set without reading the text.
// Synchronous active-low reset empties both stores and clears the overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module naive_substring_search
    import nss_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nss_in_if.sink    i_in,
    nss_out_if.source o_out
);

    t_state              r_state, n_state;
    logic [LEN_W-1:0]    r_pat_len, r_txt_len;
    logic                r_ovf;
    logic [LEN_W-1:0]    r_addr;
    logic [7:0]          r_q;
    logic                r_q_vld, n_q_vld;
    logic [ADDR_W-1:0]   r_q_idx;
    logic                r_step_vld, n_step_vld;
    logic [ADDR_W-1:0]   r_step_idx;
    logic [7:0]          r_res_pos, n_res_pos;
    logic                r_res_found, n_res_found;
    logic                r_out_vld;
    logic [7:0]          r_out_pos;
    logic                r_out_found;
    logic                r_out_ovf;
    logic [7:0]          r_txt_mem [MAX_LEN];

    logic                in_acc;
    t_op                 op;
    logic                pat_full, txt_full;
    logic                out_free;
    logic                match;
    logic [RES_W-1:0]    hit_pos;
    t_row_ctl            row_ctl;

    assign in_acc   = i_in.valid && i_in.ready;
    assign op       = t_op'(i_in.operation);
    assign pat_full = (r_pat_len == LEN_W'(MAX_LEN));
    assign txt_full = (r_txt_len == LEN_W'(MAX_LEN));
    assign out_free = !r_out_vld || o_out.ready;
    assign hit_pos  = RES_W'(r_step_idx) + RES_W'(2) - RES_W'(r_pat_len);

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        row_ctl           = '0;
        row_ctl.new_byte  = i_in.char_in;
        row_ctl.text_byte = r_q;
        row_ctl.clear     = in_acc && (op == OP_CLEAR);
        row_ctl.shift     = in_acc && (op == OP_APP_PAT) && !pat_full;
        row_ctl.start     = in_acc && (op == OP_SEARCH);
        row_ctl.step      = (r_state == ST_RUN) && r_q_vld;
    end

    nss_cell_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (row_ctl),
        .o_match (match)
    );

    always_comb begin
        n_state     = r_state;
        n_res_pos   = r_res_pos;
        n_res_found = r_res_found;
        n_q_vld     = 1'b0;
        n_step_vld  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (op == OP_SEARCH)) begin
                    if (r_pat_len == '0) begin
                        n_res_pos   = 8'd1;
                        n_res_found = 1'b1;
                        n_state     = ST_FIN;
                    end else if ((r_txt_len == '0) || (r_pat_len > r_txt_len)) begin
                        n_res_pos   = 8'd0;
                        n_res_found = 1'b0;
                        n_state     = ST_FIN;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (r_step_vld && match) begin
                    n_res_pos   = hit_pos[7:0];
                    n_res_found = 1'b1;
                    n_state     = ST_FIN;
                end else if ((r_addr == r_txt_len) && !r_q_vld && !r_step_vld) begin
                    n_res_pos   = 8'd0;
                    n_res_found = 1'b0;
                    n_state     = ST_FIN;
                end else begin
                    n_q_vld    = (r_addr < r_txt_len);
                    n_step_vld = r_q_vld;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pat_len  <= '0;
            r_txt_len  <= '0;
            r_ovf      <= 1'b0;
            r_addr     <= '0;
            r_q_vld    <= 1'b0;
            r_step_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_q_vld    <= n_q_vld;
            r_step_vld <= n_step_vld;
            if (in_acc) begin
                unique case (op)
                    OP_CLEAR: begin
                        r_pat_len <= '0;
                        r_txt_len <= '0;
                        r_ovf     <= 1'b0;
                    end
                    OP_APP_PAT: begin
                        if (pat_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_pat_len <= r_pat_len + LEN_W'(1);
                        end
                    end
                    OP_APP_TXT: begin
                        if (txt_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_txt_len <= r_txt_len + LEN_W'(1);
                        end
                    end
                    OP_SEARCH: begin
                        r_addr <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (n_q_vld) begin
                r_addr <= r_addr + LEN_W'(1);
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (op == OP_APP_TXT) && !txt_full) begin
            r_txt_mem[r_txt_len[ADDR_W-1:0]] <= i_in.char_in;
        end
        if (n_q_vld) begin
            r_q     <= r_txt_mem[r_addr[ADDR_W-1:0]];
            r_q_idx <= r_addr[ADDR_W-1:0];
        end
        if (n_step_vld) begin
            r_step_idx <= r_q_idx;
        end
        r_res_pos   <= n_res_pos;
        r_res_found <= n_res_found;
        if ((r_state == ST_FIN) && out_free) begin
            r_out_pos   <= r_res_pos;
            r_out_found <= r_res_found;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.position   = r_out_pos;
    assign o_out.found      = r_out_found;
    assign o_out.overflowed = r_out_ovf;

endmodule

`default_nettype wire

### rtl/nss_cell.sv
// ----------------------------------------------------------------------------
// nss_cell: one pattern cell
// Holds one pattern byte with its valid bit and one partial-match bit. Pattern
// bytes move up the row on append; partial matches move down it per text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nss_cell
    import nss_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_row_ctl   i_ctl,
    input  wire logic [7:0] i_prev_byte,
    input  wire logic       i_prev_vld,
    input  wire logic       i_next_d,
    input  wire logic       i_next_vld,
    output logic      [7:0] o_byte,
    output logic            o_vld,
    output logic            o_d
);

    logic [7:0] r_byte;
    logic       r_vld;
    logic       r_d;
    logic       n_d;

    // A cell beyond the start of the pattern passes a match through.
    assign n_d = (r_byte == i_ctl.text_byte) && (i_next_vld ? i_next_d : 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_d   <= 1'b0;
        end else begin
            if (i_ctl.clear) begin
                r_vld <= 1'b0;
            end else if (i_ctl.shift) begin
                r_vld <= i_prev_vld;
            end
            if (i_ctl.start) begin
                r_d <= 1'b0;
            end else if (i_ctl.step) begin
                r_d <= n_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_byte <= i_prev_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_vld  = r_vld;
    assign o_d    = r_d;

endmodule

`default_nettype wire

### rtl/nss_cell_row.sv
// ----------------------------------------------------------------------------
// nss_cell_row: chain of pattern cells
// Cell 0 holds the last pattern byte; its match bit flags a full match that
// ends at the text byte of the previous step.
// ----------------------------------------------------------------------------
`default_nettype none

module nss_cell_row
    import nss_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_row_ctl i_ctl,
    output logic          o_match
);

    logic [7:0] w_byte [MAX_LEN];
    logic       w_vld  [MAX_LEN];
    logic       w_d    [MAX_LEN];

    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        logic [7:0] prev_byte;
        logic       prev_vld;
        logic       next_d;
        logic       next_vld;

        if (j == 0) begin : g_head
            assign prev_byte = i_ctl.new_byte;
            assign prev_vld  = 1'b1;
        end else begin : g_body
            assign prev_byte = w_byte[j-1];
            assign prev_vld  = w_vld[j-1];
        end

        if (j == MAX_LEN - 1) begin : g_tail
            assign next_d   = 1'b0;
            assign next_vld = 1'b0;
        end else begin : g_link
            assign next_d   = w_d[j+1];
            assign next_vld = w_vld[j+1];
        end

        nss_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_prev_byte (prev_byte),
            .i_prev_vld  (prev_vld),
            .i_next_d    (next_d),
            .i_next_vld  (next_vld),
            .o_byte      (w_byte[j]),
            .o_vld       (w_vld[j]),
            .o_d         (w_d[j])
        );
    end

    assign o_match = w_d[0];

endmodule

`default_nettype wire

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-occurrence substring search
// Command beats that clear the stores, append bytes and start searches are
// sent through the command channel while a predictor keeps its own copy of
// both stores. Every result beat is compared field by field with the oldest
// predicted search result. Both channels stall at random in changing ratios, and a last phase runs with no stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import nss_pkg::*;

    localparam int STALL_LIMIT = 4000;

    typedef struct {
        logic [7:0] position;
        logic       found;
        logic       overflowed;
    } t_search_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    nss_in_if  cmd ();
    nss_out_if rsp ();

    naive_substring_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd),
        .o_out   (rsp)
    );

    logic [7:0]     text_bytes[$];
    logic [7:0]     pattern_bytes[$];
    logic           overflow_seen = 1'b0;
    t_search_result pending_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent    = 0;
    int mismatches    = 0;
    int stalled       = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int first_match_position();
        int  n;
        int  m;
        bit  same;
        n = text_bytes.size();
        m = pattern_bytes.size();
        if (m > n) return 0;
        for (int s = 0; s + m <= n; s++) begin
            same = 1'b1;
            for (int k = 0; k < m; k++) begin
                if (text_bytes[s + k] != pattern_bytes[k]) begin
                    same = 1'b0;
                    break;
                end
            end
            if (same) return s + 1;
        end
        return 0;
    endfunction

    function automatic void predict_command(t_op op, logic [7:0] ch);
        t_search_result res;
        int             pos;
        case (op)
            OP_CLEAR: begin
                text_bytes.delete();
                pattern_bytes.delete();
                overflow_seen = 1'b0;
            end
            OP_APP_PAT: begin
                if (pattern_bytes.size() < MAX_LEN) pattern_bytes.push_back(ch);
                else overflow_seen = 1'b1;
            end
            OP_APP_TXT: begin
                if (text_bytes.size() < MAX_LEN) text_bytes.push_back(ch);
                else overflow_seen = 1'b1;
            end
            default: begin
                pos            = first_match_position();
                res.position   = pos[7:0];
                res.found      = (pos != 0);
                res.overflowed = overflow_seen;
                pending_results.push_back(res);
            end
        endcase
    endfunction

    task automatic send_cmd(t_op op, logic [7:0] ch);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd.valid     <= 1'b1;
        cmd.operation <= op;
        cmd.char_in   <= ch;
        do @(posedge i_clk); while (!cmd.ready);
        predict_command(op, ch);
        items_sent++;
    endtask

    task automatic wait_for_results();
        cmd.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_and_limits();
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_APP_TXT, 8'h00);
        send_cmd(OP_SEARCH, 8'hFF);
        send_cmd(OP_APP_PAT, 8'hFF);
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_APP_PAT, 8'h00);
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_CLEAR, 8'hFF);
        send_cmd(OP_APP_TXT, 8'h00);
        send_cmd(OP_APP_TXT, 8'hFF);
        send_cmd(OP_APP_TXT, 8'h00);
        send_cmd(OP_APP_TXT, 8'hFF);
        send_cmd(OP_APP_TXT, 8'h5A);
        send_cmd(OP_APP_PAT, 8'hFF);
        send_cmd(OP_APP_PAT, 8'h00);
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_APP_PAT, 8'hFF);
        send_cmd(OP_APP_PAT, 8'h5A);
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_CLEAR, 8'h00);
        send_cmd(OP_APP_TXT, 8'h5A);
        send_cmd(OP_APP_TXT, 8'hA5);
        send_cmd(OP_APP_PAT, 8'h5A);
        send_cmd(OP_APP_PAT, 8'hA5);
        send_cmd(OP_SEARCH, 8'hFF);
    endtask

    task automatic test_store_overflow();
        logic [7:0] b;
        send_cmd(OP_CLEAR, 8'hA5);
        for (int k = 0; k < MAX_LEN + 2; k++) begin
            b = (k >= MAX_LEN - 1) ? 8'hA5 : 8'($urandom_range(8'hA4));
            send_cmd(OP_APP_TXT, b);
        end
        send_cmd(OP_APP_PAT, 8'hA5);
        send_cmd(OP_SEARCH, 8'h00);
        send_cmd(OP_CLEAR, 8'h00);
        send_cmd(OP_SEARCH, 8'h00);
        for (int k = 0; k < MAX_LEN; k++) begin
            b = 8'($urandom);
            send_cmd(OP_APP_TXT, b);
            send_cmd(OP_APP_PAT, b);
        end
        send_cmd(OP_APP_PAT, 8'h00);
        send_cmd(OP_SEARCH, 8'hFF);
    endtask

    task automatic test_random_sequences(int budget);
        int         stop_at;
        int         text_len;
        int         pat_len;
        int         start;
        logic [7:0] alphabet[3];
        logic [7:0] txt[$];
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            if ($urandom_range(14) == 0) wait_for_results();
            if ($urandom_range(99) < 80) begin
                foreach (alphabet[i]) alphabet[i] = 8'($urandom);
                text_len = ($urandom_range(39) == 0) ? $urandom_range(MAX_LEN - 4, MAX_LEN + 2)
                                                     : $urandom_range(12);
                txt.delete();
                send_cmd(OP_CLEAR, 8'($urandom));
                for (int k = 0; k < text_len; k++) begin
                    txt.push_back(alphabet[$urandom_range(2)]);
                    send_cmd(OP_APP_TXT, txt[k]);
                end
                if ($urandom_range(1) == 1) begin
                    start   = $urandom_range(txt.size());
                    pat_len = $urandom_range(txt.size() - start);
                    if (pat_len > 6 && $urandom_range(3) != 0) pat_len = $urandom_range(1, 6);
                    for (int k = 0; k < pat_len; k++) send_cmd(OP_APP_PAT, txt[start + k]);
                end else begin
                    pat_len = $urandom_range(6);
                    for (int k = 0; k < pat_len; k++) begin
                        send_cmd(OP_APP_PAT, alphabet[$urandom_range(2)]);
                    end
                end
                send_cmd(OP_SEARCH, 8'($urandom));
                if ($urandom_range(2) == 0) begin
                    send_cmd($urandom_range(1) ? OP_APP_TXT : OP_APP_PAT,
                             alphabet[$urandom_range(2)]);
                    send_cmd(OP_SEARCH, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_cmd(t_op'($urandom_range(3)), 8'($urandom));
            end
        end
    endtask

    initial begin
        rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_search_result want;
        if (i_rst_n && rsp.valid && rsp.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no search pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (rsp.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, rsp.position);
                    mismatches++;
                end
                if (rsp.found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, rsp.found);
                    mismatches++;
                end
                if (rsp.overflowed !== want.overflowed) begin
                    $error("overflowed: expected %0b, got %0b", want.overflowed,
                           rsp.overflowed);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
            stalled = 0;
        end else begin
            stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        cmd.valid     <= 1'b0;
        cmd.operation <= OP_CLEAR;
        cmd.char_in   <= 8'h00;
        send_idle_pct = 28;
        recv_idle_pct = 64;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_and_limits();
        wait_for_results();
        test_store_overflow();
        wait_for_results();
        test_random_sequences(70);
        wait_for_results();

        send_idle_pct = 64;
        recv_idle_pct = 28;
        test_random_sequences(70);
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(70);
        wait_for_results();

        repeat (MAX_LEN + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
